// ===== src/bmts_pkg.sv =====
// ----------------------------------------------------------------------------
// bmts_pkg
// Types and constants shared by the bus master transaction sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bmts_pkg;

  // register indexes on the configuration port
  localparam int unsigned CfgIndexWidth = 8;
  localparam int unsigned CfgDataWidth  = 20;

  localparam logic [CfgIndexWidth-1:0] REG_MIN_SPACING_US     = 8'd0;
  localparam logic [CfgIndexWidth-1:0] REG_POLL_INTERVAL_US   = 8'd1;
  localparam logic [CfgIndexWidth-1:0] REG_RECEIVE_TIMEOUT_MS = 8'd2;
  localparam logic [CfgIndexWidth-1:0] REG_RETRY_LIMIT        = 8'd3;

  // register reset values
  localparam logic [19:0] MIN_SPACING_RESET     = 20'd1000;
  localparam logic [19:0] POLL_INTERVAL_RESET   = 20'd500;
  localparam logic [15:0] RECEIVE_TIMEOUT_RESET = 16'd100;
  localparam logic [7:0]  RETRY_LIMIT_RESET     = 8'd3;

  // stream payload widths
  localparam int unsigned InDataWidth  = 72;
  localparam int unsigned OutDataWidth = 8;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_SEND       = 3'd1,
    PH_WAIT_POLL  = 3'd2,
    PH_WAIT_READY = 3'd3,
    PH_RECEIVE    = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_WAIT       = 3'd1,
    ST_WRITE_ERR  = 3'd2,
    ST_RX_TIMEOUT = 3'd3,
    ST_RX_FULL    = 3'd4,
    ST_CHECKSUM   = 3'd5,
    ST_OK         = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0]  retry_limit;
    logic [15:0] receive_timeout_ms;
    logic [19:0] poll_interval_us;
    logic [19:0] min_spacing_us;
  } cfg_t;

  typedef struct packed {
    logic        checksum_ok;
    logic        rx_full;
    logic        read_ok;
    logic        poll_ready;
    logic        write_ok;
    logic        tx_pending;
    logic [31:0] now_ms;
    logic [31:0] now_us;
  } item_t;

  typedef struct packed {
    logic    rx_push;
    logic    tx_pop;
    logic    did_read;
    logic    did_poll;
    logic    did_write;
    status_t status;
  } result_t;

endpackage

`default_nettype wire

// ===== src/bmts_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bmts_cfg_regs
// Configuration register file: spacing, poll interval, timeout, retry limit.
// ----------------------------------------------------------------------------
`default_nettype none

module bmts_cfg_regs
  import bmts_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire logic [CfgIndexWidth-1:0] wr_index,
  input  wire logic [CfgDataWidth-1:0]  wr_data,
  output cfg_t                          cfg
);

  cfg_t regs;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.min_spacing_us     <= MIN_SPACING_RESET;
      regs.poll_interval_us   <= POLL_INTERVAL_RESET;
      regs.receive_timeout_ms <= RECEIVE_TIMEOUT_RESET;
      regs.retry_limit        <= RETRY_LIMIT_RESET;
    end else if (wr_en) begin
      if (wr_index == REG_MIN_SPACING_US) begin
        regs.min_spacing_us <= wr_data;
      end
      if (wr_index == REG_POLL_INTERVAL_US) begin
        regs.poll_interval_us <= wr_data;
      end
      if (wr_index == REG_RECEIVE_TIMEOUT_MS) begin
        regs.receive_timeout_ms <= wr_data[15:0];
      end
      if (wr_index == REG_RETRY_LIMIT) begin
        regs.retry_limit <= wr_data[7:0];
      end
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// ===== src/bmts_core.sv =====
// ----------------------------------------------------------------------------
// bmts_core
// Sequencer state and the single-pass phase walk for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module bmts_core
  import bmts_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step,
  input  cfg_t      cfg,
  input  item_t     item,
  output result_t   res
);

  phase_t      phase, phase_next;
  logic [31:0] last_task_us, last_task_us_next;
  logic [31:0] last_task_ms, last_task_ms_next;
  logic [31:0] last_poll_us, last_poll_us_next;
  logic [7:0]  retry_count, retry_count_next;
  logic        done;
  result_t     res_w;

  // walk the phases in order, stop at the first wait or final outcome
  always_comb begin
    phase_next        = phase;
    last_task_us_next = last_task_us;
    last_task_ms_next = last_task_ms;
    last_poll_us_next = last_poll_us;
    retry_count_next  = retry_count;
    done              = 1'b0;
    res_w             = '0;
    res_w.status      = ST_IDLE;

    // codes outside the enum restart from idle
    unique case (phase)
      PH_IDLE, PH_SEND, PH_WAIT_POLL, PH_WAIT_READY, PH_RECEIVE: phase_next = phase;
      default: phase_next = PH_IDLE;
    endcase

    // idle: pick up a queued message
    if (phase_next == PH_IDLE) begin
      if (!item.tx_pending) begin
        done = 1'b1;
      end else begin
        retry_count_next = '0;
        phase_next       = PH_SEND;
      end
    end

    // send: spacing check, then one write attempt
    if (!done && phase_next == PH_SEND) begin
      if ((item.now_us - last_task_us_next) < {12'd0, cfg.min_spacing_us}) begin
        res_w.status = ST_WAIT;
        done         = 1'b1;
      end else begin
        last_task_ms_next = item.now_ms;
        last_task_us_next = item.now_us;
        res_w.did_write   = 1'b1;
        if (!item.write_ok) begin
          retry_count_next = retry_count_next + 8'd1;
          res_w.status     = ST_WRITE_ERR;
          done             = 1'b1;
          if (retry_count_next >= cfg.retry_limit) begin
            phase_next   = PH_IDLE;
            res_w.tx_pop = 1'b1;
          end
        end else begin
          res_w.tx_pop = 1'b1;
          phase_next   = PH_WAIT_POLL;
        end
      end
    end

    // wait before the first poll
    if (!done && phase_next == PH_WAIT_POLL) begin
      if ((item.now_us - last_task_us_next) < {12'd0, cfg.min_spacing_us}) begin
        res_w.status = ST_WAIT;
        done         = 1'b1;
      end else begin
        last_poll_us_next = item.now_us;
        last_task_us_next = item.now_us;
        last_task_ms_next = item.now_ms;
        phase_next        = PH_WAIT_READY;
      end
    end

    // timeout check, then poll at the interval
    if (!done && phase_next == PH_WAIT_READY) begin
      if ((item.now_ms - last_task_ms_next) > {16'd0, cfg.receive_timeout_ms}) begin
        phase_next   = PH_IDLE;
        res_w.status = ST_RX_TIMEOUT;
        done         = 1'b1;
      end else if ((item.now_us - last_poll_us_next) < {12'd0, cfg.poll_interval_us}) begin
        res_w.status = ST_WAIT;
        done         = 1'b1;
      end else begin
        last_poll_us_next = item.now_us;
        res_w.did_poll    = 1'b1;
        if (item.poll_ready) begin
          phase_next = PH_RECEIVE;
        end
      end
    end

    // spacing check, then read the reply and judge it
    if (!done && phase_next == PH_RECEIVE) begin
      if ((item.now_us - last_task_us_next) < {12'd0, cfg.min_spacing_us}) begin
        res_w.status = ST_WAIT;
      end else begin
        last_task_ms_next = item.now_ms;
        last_task_us_next = item.now_us;
        res_w.did_read    = 1'b1;
        phase_next        = PH_IDLE;
        priority if (!item.read_ok) begin
          res_w.status = ST_RX_TIMEOUT;
        end else if (item.rx_full) begin
          res_w.status = ST_RX_FULL;
        end else if (!item.checksum_ok) begin
          res_w.status = ST_CHECKSUM;
        end else begin
          res_w.status  = ST_OK;
          res_w.rx_push = 1'b1;
        end
      end
    end
  end

  // state registers advance once per processed request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      last_task_us <= '0;
      last_task_ms <= '0;
      last_poll_us <= '0;
      retry_count  <= '0;
    end else if (step) begin
      phase        <= phase_next;
      last_task_us <= last_task_us_next;
      last_task_ms <= last_task_ms_next;
      last_poll_us <= last_poll_us_next;
      retry_count  <= retry_count_next;
    end
  end

  assign res = res_w;

endmodule

`default_nettype wire

// ===== src/bus_master_transaction_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// bus_master_transaction_sequencer_unit
// Sequences message write, ready polling and reply read for a bus master.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_ channel is one service pass of the master: the
//   current microsecond and millisecond times, whether a message is queued,
//   and the outcomes of any write, poll or read made in that pass. Each
//   request yields exactly one result on the m_ channel: a status code and
//   flags for the write, poll and read issued and for queue pop and push.
//   The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data)
//   sets spacing, poll interval, timeout and retry limit; it is always
//   ready and should be written only while no request is in flight.
//   A request is captured in the input register, processed by the core, and
//   its result lands in the result register that drives m_tdata. Throughput:
//   one request per cycle while m_tready is high; the whole phase walk is a
//   short chain of 32-bit subtract-compare checks between the two registers.
//   When the receiver stalls, the result register holds, the input register
//   takes one more request, and then s_tready drops until m_tready returns.
//   Reset (rst, synchronous) empties both registers, puts the sequencer in
//   idle with all timestamps and the retry count at zero, and loads the
//   register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module bus_master_transaction_sequencer_unit
  import bmts_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  // request channel
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  // now_us[31:0], now_ms[63:32], tx_pending[64], write_ok[65], poll_ready[66],
  // read_ok[67], rx_full[68], checksum_ok[69], zero[71:70]
  input  wire logic [InDataWidth-1:0]   s_tdata,
  // result channel
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // status[2:0], did_write[3], did_poll[4], did_read[5], tx_pop[6], rx_push[7]
  output logic [OutDataWidth-1:0]       m_tdata,
  // configuration write channel
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_data
);

  cfg_t    cfg;
  item_t   in_q;
  logic    in_valid;
  result_t res;
  result_t out_q;
  logic    out_valid;
  logic    step;
  logic    s_accept;

  assign cfg_ready = 1'b1;

  bmts_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // process when a request is held and the result register is free
  assign step     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || step;
  assign s_accept = s_tvalid && s_tready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_q <= s_tdata[$bits(item_t)-1:0];
    end
  end

  bmts_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .cfg  (cfg),
    .item (in_q),
    .res  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_q;

  // a pushed reply was read and judged good
  a_push_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_q.rx_push |-> out_q.did_read && out_q.status == ST_OK)
    else $error("reply pushed without a good read");

  // a pop only follows a write attempt
  a_pop_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_q.tx_pop |-> out_q.did_write)
    else $error("transmit pop without a write");

  // a processed request always lands in the result register
  a_step_result: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("processed request lost");

  // a read always ends the transaction with a final status
  a_read_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_q.did_read |-> out_q.status == ST_RX_TIMEOUT ||
      out_q.status == ST_RX_FULL || out_q.status == ST_CHECKSUM ||
      out_q.status == ST_OK)
    else $error("read without final status");

endmodule

`default_nettype wire
